// File: rtl/smt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and constants for the streaming substring matcher.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  localparam int MATCH_W    = 16;  // width of reported indexes
  localparam int PLEN_W     = 5;   // width of the pattern length register
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    REG_PATTERN_LO  = 2'd0,
    REG_PATTERN_HI  = 2'd1,
    REG_PATTERN_LEN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_start;
    logic [MATCH_W-1:0] match_end;
  } result_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_status_t;

endpackage : smt_pkg
`default_nettype wire

// File: rtl/smt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_front
// Accepts text bytes, keeps the window and position, compares the newest
// bytes with the pattern and pushes a result when one is due.
// ----------------------------------------------------------------------------
module smt_front import smt_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          text_byte,
  input  wire logic                text_last,
  input  wire logic [63:0]         pattern_lo,
  input  wire logic [63:0]         pattern_hi,
  input  wire logic [PLEN_W-1:0]   pattern_len,
  input  wire fifo_status_t        fifo_st,
  output logic                     push,
  output result_t                  res
);

  localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
  localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [7:0]               window [MAX_PATTERN];
  logic [7:0]               win_new [MAX_PATTERN];
  logic [FILL_W-1:0]        fill_count;
  logic [FILL_W-1:0]        fill_next;
  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] position_next;
  logic                     already_found;

  logic [FILL_W-1:0] eff_len;
  logic [FILL_W-1:0] idx_w;
  logic [127:0]      pat_all;
  logic              match_all;
  logic              hit;
  logic              accept;
  logic [31:0]       p_ext;
  logic [31:0]       start32;

  assign in_stall = fifo_st.full;
  assign accept   = in_valid && !in_stall;
  assign pat_all  = {pattern_hi, pattern_lo};

  // Length zero acts as one, above the window acts as the window.
  always_comb begin
    priority if (pattern_len == '0) begin
      eff_len = FILL_W'(1);
    end else if (pattern_len > PLEN_W'(MAX_PATTERN)) begin
      eff_len = FILL_W'(MAX_PATTERN);
    end else begin
      eff_len = FILL_W'(pattern_len);
    end
  end

  always_comb begin
    win_new[0] = text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_new[i] = window[i-1];
    end
  end

  // Pattern byte j lines up with window entry len-1-j.
  always_comb begin
    match_all = 1'b1;
    idx_w     = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (FILL_W'(j) < eff_len) begin
        idx_w = eff_len - FILL_W'(j) - FILL_W'(1);
        if (win_new[idx_w[WIN_IDX_W-1:0]] != pat_all[8*j +: 8]) begin
          match_all = 1'b0;
        end
      end
    end
  end

  assign fill_next     = (fill_count < FILL_W'(MAX_PATTERN)) ? fill_count + FILL_W'(1)
                                                             : fill_count;
  assign position_next = (position != POS_MAX) ? position + POSITION_BITS'(1) : position;

  assign hit = !already_found && (position != POS_MAX) && (fill_next >= eff_len) && match_all;

  assign p_ext   = 32'(position);
  assign start32 = p_ext - 32'(eff_len) + 32'd1;

  always_comb begin
    push = accept && (hit || (text_last && !already_found));
    res.found       = hit;
    res.match_start = hit ? start32[MATCH_W-1:0] : '0;
    res.match_end   = hit ? p_ext[MATCH_W-1:0]   : '0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= win_new[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      position      <= '0;
      already_found <= 1'b0;
    end else if (accept) begin
      if (text_last) begin
        // drop the text state; the pattern stays
        fill_count    <= '0;
        position      <= '0;
        already_found <= 1'b0;
      end else begin
        fill_count    <= fill_next;
        position      <= position_next;
        already_found <= already_found || hit;
      end
    end
  end

endmodule : smt_front
`default_nettype wire

// File: rtl/smt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_fifo
// Short result queue between the compare front and the output stage.
// ----------------------------------------------------------------------------
module smt_fifo import smt_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t wr_data,
  input  wire logic    pop,
  output result_t      rd_data,
  output fifo_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full      = (count == CNT_W'(DEPTH));
  assign status.not_empty = (count != '0);
  assign rd_data          = entries[rd_ptr];
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule : smt_fifo
`default_nettype wire

// File: rtl/smt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_back
// Output register: pulls results from the queue and holds them for the
// receiver until the transaction completes.
// ----------------------------------------------------------------------------
module smt_back import smt_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fifo_status_t  fifo_st,
  input  wire result_t       head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output result_t            out_res
);

  assign pop = fifo_st.not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule : smt_back
`default_nettype wire

// File: rtl/substring_match_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// substring_match_stream
// Streaming exact substring search over byte-wide text.
//
// Text bytes enter on in_valid/in_stall with text_last on the final byte.
// The block reports one result per text: found with the start and end
// index of the first match, or not found when the text ends without one.
// Results leave on out_valid/out_stall.
// Throughput is one byte per cycle while the result queue is not full;
// the window compare is a set of parallel combinational byte compares.
// A result is written into the result queue when its byte is accepted,
// then moves from the queue into the output register.
// When the receiver stalls, results collect in the two-entry queue; the
// input stalls only while that queue is full.
// Reset clears the text state, the queue and the output valid, and sets
// the pattern to zero with length one. APB pattern registers sit at byte
// addresses 0, 8, 16; the user must write them only while idle (unenforced).
// ----------------------------------------------------------------------------
module substring_match_stream import smt_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            text_byte,
  input  wire logic                  text_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       found,
  output logic [MATCH_W-1:0]         match_start,
  output logic [MATCH_W-1:0]         match_end,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [63:0]       pattern_lo;
  logic [63:0]       pattern_hi;
  logic [PLEN_W-1:0] pattern_len;
  cfg_reg_e          reg_sel;
  logic              cfg_wr;

  fifo_status_t fifo_st;
  result_t      push_res;
  result_t      head;
  result_t      out_res;
  logic         push;
  logic         pop;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_lo  <= '0;
      pattern_hi  <= '0;
      pattern_len <= PLEN_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PATTERN_LO:  pattern_lo  <= pwdata;
        REG_PATTERN_HI:  pattern_hi  <= pwdata;
        REG_PATTERN_LEN: pattern_len <= pwdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LO:  prdata = pattern_lo;
      REG_PATTERN_HI:  prdata = pattern_hi;
      REG_PATTERN_LEN: prdata = CFG_DATA_W'(pattern_len);
      default:         prdata = '0;
    endcase
  end

  smt_front #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .text_last   (text_last),
    .pattern_lo  (pattern_lo),
    .pattern_hi  (pattern_hi),
    .pattern_len (pattern_len),
    .fifo_st     (fifo_st),
    .push        (push),
    .res         (push_res)
  );

  smt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_res),
    .pop     (pop),
    .rd_data (head),
    .status  (fifo_st)
  );

  smt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_st   (fifo_st),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign found       = out_res.found;
  assign match_start = out_res.match_start;
  assign match_end   = out_res.match_end;

endmodule : substring_match_stream
`default_nettype wire

// File: rtl/smt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_assertions
// Port-level checks for the substring matcher, bound to the top level.
// ----------------------------------------------------------------------------
module smt_assertions import smt_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               found,
  input wire logic [MATCH_W-1:0] match_start,
  input wire logic [MATCH_W-1:0] match_end,
  input wire logic               pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (match_start == '0) && (match_end == '0))
    else $error("not-found result carries nonzero indexes");

  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (MATCH_W'(match_end - match_start) < MATCH_W'(MAX_PATTERN)))
    else $error("match span longer than the pattern window");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && pready)
    else $error("output valid right after reset");

endmodule : smt_assertions

bind substring_match_stream smt_assertions #(.MAX_PATTERN(MAX_PATTERN)) u_smt_checker (.*);
`default_nettype wire
